### src/epafu_pkg.sv
`default_nettype none

package epafu_pkg;

	// operation codes
	localparam logic [2:0] CMD_IN  = 3'd0;
	localparam logic [2:0] CMD_ADC = 3'd1;
	localparam logic [2:0] CMD_SBC = 3'd2;
	localparam logic [2:0] CMD_LDI = 3'd3;
	localparam logic [2:0] CMD_RLD = 3'd4;
	localparam logic [2:0] CMD_RRD = 3'd5;

	// flag bit positions
	localparam int unsigned FL_C  = 0;
	localparam int unsigned FL_N  = 1;
	localparam int unsigned FL_PV = 2;
	localparam int unsigned FL_F3 = 3;
	localparam int unsigned FL_H  = 4;
	localparam int unsigned FL_F5 = 5;
	localparam int unsigned FL_Z  = 6;
	localparam int unsigned FL_S  = 7;

	// one operation with all of its operands
	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] hl;
		logic [15:0] pair;
		logic [7:0]  acc;
		logic [7:0]  data;
		logic [7:0]  ir;
		logic [7:0]  flags;
		logic        iff2;
		logic [15:0] bc;
	} op_t;

	// one result word
	typedef struct packed {
		logic [15:0] hl;
		logic [7:0]  acc;
		logic [7:0]  mem;
		logic [7:0]  flags;
		logic [15:0] memptr;
	} res_t;

	// S, Z, F5, F3 and parity from a byte, H = N = 0, carry kept
	function automatic logic [7:0] byte_flags(input logic c, input logic [7:0] b);
		logic [7:0] f;
		f        = 8'h00;
		f[FL_C]  = c;
		f[FL_S]  = b[7];
		f[FL_F5] = b[5];
		f[FL_F3] = b[3];
		f[FL_Z]  = (b == 8'h00);
		f[FL_PV] = ~^b;
		return f;
	endfunction

endpackage

`default_nettype wire

### src/epafu_alu.sv
`default_nettype none

module epafu_alu (
	input  wire  epafu_pkg::op_t  op,
	output epafu_pkg::res_t       res
);
	import epafu_pkg::*;

	logic        c_in;
	logic [16:0] add_w;
	logic [12:0] add_lo;
	logic [16:0] sub_w;
	logic [12:0] sub_lo;
	logic [15:0] hl_inc;
	logic [15:0] bc_inc;
	logic [7:0]  rld_acc;
	logic [7:0]  rrd_acc;

	assign c_in    = op.flags[FL_C];
	assign add_w   = {1'b0, op.hl} + {1'b0, op.pair} + {16'd0, c_in};
	assign add_lo  = {1'b0, op.hl[11:0]} + {1'b0, op.pair[11:0]} + {12'd0, c_in};
	assign sub_w   = {1'b0, op.hl} - {1'b0, op.pair} - {16'd0, c_in};
	assign sub_lo  = {1'b0, op.hl[11:0]} - {1'b0, op.pair[11:0]} - {12'd0, c_in};
	assign hl_inc  = op.hl + 16'd1;
	assign bc_inc  = op.bc + 16'd1;
	assign rld_acc = {op.acc[7:4], op.data[7:4]};
	assign rrd_acc = {op.acc[7:4], op.data[3:0]};

	always_comb begin
		res.hl     = op.hl;
		res.acc    = op.acc;
		res.mem    = 8'h00;
		res.flags  = op.flags;
		res.memptr = 16'h0000;
		case (op.cmd)
			CMD_IN: begin
				res.flags  = byte_flags(c_in, op.data);
				res.memptr = bc_inc;
			end
			CMD_ADC: begin
				res.hl            = add_w[15:0];
				res.flags         = 8'h00;
				res.flags[FL_S]   = add_w[15];
				res.flags[FL_F5]  = add_w[13];
				res.flags[FL_F3]  = add_w[11];
				res.flags[FL_Z]   = (add_w[15:0] == 16'h0000);
				res.flags[FL_PV]  = ~(op.hl[15] ^ op.pair[15]) & (op.hl[15] ^ add_w[15]);
				res.flags[FL_C]   = add_w[16];
				res.flags[FL_H]   = add_lo[12];
				res.memptr        = hl_inc;
			end
			CMD_SBC: begin
				res.hl            = sub_w[15:0];
				res.flags         = 8'h00;
				res.flags[FL_S]   = sub_w[15];
				res.flags[FL_F5]  = sub_w[13];
				res.flags[FL_F3]  = sub_w[11];
				res.flags[FL_Z]   = (sub_w[15:0] == 16'h0000);
				res.flags[FL_PV]  = (op.hl[15] ^ op.pair[15]) & (op.hl[15] ^ sub_w[15]);
				res.flags[FL_C]   = sub_w[16];
				res.flags[FL_N]   = 1'b1;
				res.flags[FL_H]   = sub_lo[12];
				res.memptr        = hl_inc;
			end
			CMD_LDI: begin
				res.acc           = op.ir;
				res.flags         = byte_flags(c_in, op.ir);
				res.flags[FL_PV]  = op.iff2;
			end
			CMD_RLD: begin
				res.mem    = {op.data[3:0], op.acc[3:0]};
				res.acc    = rld_acc;
				res.flags  = byte_flags(c_in, rld_acc);
				res.memptr = hl_inc;
			end
			CMD_RRD: begin
				res.mem    = {op.acc[3:0], op.data[7:4]};
				res.acc    = rrd_acc;
				res.flags  = byte_flags(c_in, rrd_acc);
				res.memptr = hl_inc;
			end
			default: begin
				// unknown codes leave everything as it was
				res.hl = op.hl;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/ed_page_alu_flag_unit.sv
`default_nettype none

// channel   handshake        payload
// command   start / busy     cmd hl_in operand_pair acc_in data_byte ir_value
//                            flags_in iff2_in port_pair
// result    done (strobe)    hl_out acc_out mem_out flags_out memptr_out
//
// one command word is taken per cycle while busy is low; its result word
// appears after acceptance through the input register, then the result
// register, with done high for a single cycle
// throughput is one word per clock once busy is low, set by the single add/subtract stage
// busy is high during reset and until the first clock edge after reset is released
// the receiver cannot stall; results are never held back

module ed_page_alu_flag_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  cmd,
	input  wire  [15:0] hl_in,
	input  wire  [15:0] operand_pair,
	input  wire  [7:0]  acc_in,
	input  wire  [7:0]  data_byte,
	input  wire  [7:0]  ir_value,
	input  wire  [7:0]  flags_in,
	input  wire         iff2_in,
	input  wire  [15:0] port_pair,
	output logic        done,
	output logic [15:0] hl_out,
	output logic [7:0]  acc_out,
	output logic [7:0]  mem_out,
	output logic [7:0]  flags_out,
	output logic [15:0] memptr_out
);
	import epafu_pkg::*;

	logic   busy_q;
	logic   vld_s1;
	logic   vld_s2;
	logic   accept;
	op_t    op_s1;
	res_t   res_comb;
	res_t   res_s2;

	assign accept = start & ~busy_q;

	// busy covers the cycle right after reset only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.cmd   <= cmd;
			op_s1.hl    <= hl_in;
			op_s1.pair  <= operand_pair;
			op_s1.acc   <= acc_in;
			op_s1.data  <= data_byte;
			op_s1.ir    <= ir_value;
			op_s1.flags <= flags_in;
			op_s1.iff2  <= iff2_in;
			op_s1.bc    <= port_pair;
		end
	end

	epafu_alu u_alu (
		.op  (op_s1),
		.res (res_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign busy       = busy_q;
	assign done       = vld_s2;
	assign hl_out     = res_s2.hl;
	assign acc_out    = res_s2.acc;
	assign mem_out    = res_s2.mem;
	assign flags_out  = res_s2.flags;
	assign memptr_out = res_s2.memptr;

	// every accepted word comes out through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted word produced no result");

	// a result needs a word in the input stage the cycle before
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1))
		else $error("result strobe without a word in flight");

	// only the digit rotates write a memory byte
	a_mem_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (mem_out != 8'h00)) |->
			($past(op_s1.cmd) == CMD_RLD || $past(op_s1.cmd) == CMD_RRD))
		else $error("memory byte from an operation that writes none");

	// n is set only by subtraction or kept by an unknown code
	a_n_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && flags_out[FL_N]) |->
			($past(op_s1.cmd) == CMD_SBC || $past(op_s1.cmd) > CMD_RRD))
		else $error("n flag set by an add-type operation");

	// once out of reset the unit never blocks
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("busy reasserted after reset");

endmodule

`default_nettype wire

### tb/ed_page_alu_flag_unit_tb.sv
`timescale 1ns / 1ps

module ed_page_alu_flag_unit_tb;
	import epafu_pkg::*;

	// codes the block treats as no operation
	localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 8;
	// result word shows after the input and result registers, wait a little longer
	localparam int TAIL_CYCLES = 6;
	// far beyond the slowest legal run (about 1500 words with random gaps)
	localparam int RUN_LIMIT_CYCLES = 200000;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	op_t cmd_word = '0;

	logic busy;
	logic done;
	logic [15:0] hl_out;
	logic [7:0] acc_out;
	logic [7:0] mem_out;
	logic [7:0] flags_out;
	logic [15:0] memptr_out;

	// predicted result words, oldest first
	res_t pending_results[$];
	int unsigned mismatch_count = 0;
	// random gaps on the command side, cleared for a quiet stretch
	bit gaps_on = 1'b1;

	res_t seen_word;
	res_t oldest_word;

	ed_page_alu_flag_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd_word.cmd),
		.hl_in       (cmd_word.hl),
		.operand_pair(cmd_word.pair),
		.acc_in      (cmd_word.acc),
		.data_byte   (cmd_word.data),
		.ir_value    (cmd_word.ir),
		.flags_in    (cmd_word.flags),
		.iff2_in     (cmd_word.iff2),
		.port_pair   (cmd_word.bc),
		.done        (done),
		.hl_out      (hl_out),
		.acc_out     (acc_out),
		.mem_out     (mem_out),
		.flags_out   (flags_out),
		.memptr_out  (memptr_out)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// flag and datapath predictor
	// ------------------------------------------------------------------

	// sign, zero, the two copy bits and even parity of a byte, carry kept
	function automatic logic [7:0] flags_of_byte(input logic carry, input logic [7:0] b);
		logic [7:0] f;
		f = 8'h00;
		f[FL_S] = b[7];
		f[FL_Z] = (b == 8'h00);
		f[FL_F5] = b[5];
		f[FL_F3] = b[3];
		f[FL_PV] = ~^b;
		f[FL_C] = carry;
		return f;
	endfunction

	function automatic res_t predict_result(input op_t w);
		res_t r;
		logic [16:0] wide;
		logic [12:0] low12;
		logic [15:0] val;
		logic cin;
		cin = w.flags[FL_C];
		// defaults: pass hl, acc and flags, no memory byte, no memptr
		r.hl = w.hl;
		r.acc = w.acc;
		r.mem = 8'h00;
		r.flags = w.flags;
		r.memptr = 16'h0000;
		case (w.cmd)
			CMD_IN: begin
				r.flags = flags_of_byte(cin, w.data);
				r.memptr = w.bc + 16'd1;
			end
			CMD_ADC: begin
				wide = {1'b0, w.hl} + {1'b0, w.pair} + {16'd0, cin};
				low12 = {1'b0, w.hl[11:0]} + {1'b0, w.pair[11:0]} + {12'd0, cin};
				val = wide[15:0];
				r.flags = 8'h00;
				r.flags[FL_S] = val[15];
				r.flags[FL_Z] = (val == 16'h0000);
				r.flags[FL_F5] = val[13];
				r.flags[FL_H] = low12[12];
				r.flags[FL_F3] = val[11];
				// same operand signs, result sign differs
				r.flags[FL_PV] = ~(w.hl[15] ^ w.pair[15]) & (w.hl[15] ^ val[15]);
				r.flags[FL_C] = wide[16];
				r.hl = val;
				r.memptr = w.hl + 16'd1;
			end
			CMD_SBC: begin
				// a borrow out of either width leaves the top bit set
				wide = {1'b0, w.hl} - {1'b0, w.pair} - {16'd0, cin};
				low12 = {1'b0, w.hl[11:0]} - {1'b0, w.pair[11:0]} - {12'd0, cin};
				val = wide[15:0];
				r.flags = 8'h00;
				r.flags[FL_S] = val[15];
				r.flags[FL_Z] = (val == 16'h0000);
				r.flags[FL_F5] = val[13];
				r.flags[FL_H] = low12[12];
				r.flags[FL_F3] = val[11];
				r.flags[FL_PV] = (w.hl[15] ^ w.pair[15]) & (w.hl[15] ^ val[15]);
				r.flags[FL_N] = 1'b1;
				r.flags[FL_C] = wide[16];
				r.hl = val;
				r.memptr = w.hl + 16'd1;
			end
			CMD_LDI: begin
				r.acc = w.ir;
				r.flags = 8'h00;
				r.flags[FL_S] = w.ir[7];
				r.flags[FL_Z] = (w.ir == 8'h00);
				r.flags[FL_F5] = w.ir[5];
				r.flags[FL_F3] = w.ir[3];
				r.flags[FL_PV] = w.iff2;
				r.flags[FL_C] = cin;
			end
			CMD_RLD: begin
				r.mem = {w.data[3:0], w.acc[3:0]};
				r.acc = {w.acc[7:4], w.data[7:4]};
				r.flags = flags_of_byte(cin, r.acc);
				r.memptr = w.hl + 16'd1;
			end
			CMD_RRD: begin
				r.mem = {w.acc[3:0], w.data[7:4]};
				r.acc = {w.acc[7:4], w.data[3:0]};
				r.flags = flags_of_byte(cin, r.acc);
				r.memptr = w.hl + 16'd1;
			end
			default: begin
				// undefined codes: nothing changes
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// corner values for the 16-bit adder, otherwise fully random
	function automatic logic [15:0] pick_pair_value();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			4: return 16'h0FFF;
			5: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// every field random; adder operands lean toward carry and overflow edges
	function automatic op_t random_word();
		op_t w;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			w.cmd = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
		else
			w.cmd = 3'($urandom_range(CMD_RRD, CMD_IN));
		w.hl = ($urandom_range(2) == 0) ? pick_pair_value() : 16'($urandom);
		w.pair = ($urandom_range(2) == 0) ? pick_pair_value() : 16'($urandom);
		w.acc = 8'($urandom);
		w.data = 8'($urandom);
		w.ir = 8'($urandom);
		w.flags = 8'($urandom);
		w.iff2 = 1'($urandom);
		w.bc = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
		return w;
	endfunction

	function automatic op_t word_for(input logic [2:0] c);
		op_t w;
		w = random_word();
		w.cmd = c;
		return w;
	endfunction

	task automatic idle_cycles(input int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// drive one command word and hold it until the block takes it
	// random idle gaps before about a fifth of the words
	// keep the sender idle for roughly a third of the time
	task automatic send_word(input op_t w);
		if (gaps_on && $urandom_range(99) < 22)
			idle_cycles($urandom_range(4, 1));
		@(negedge clk);
		start = 1'b1;
		cmd_word = w;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(predict_result(w));
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic pause_until_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// result checker: the receiver never stalls, every strobe is a word
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string why, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, why);
			$display("  expected hl %h acc %h mem %h flags %b memptr %h",
				want.hl, want.acc, want.mem, want.flags, want.memptr);
			$display("  actual   hl %h acc %h mem %h flags %b memptr %h",
				got.hl, got.acc, got.mem, got.flags, got.memptr);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			seen_word = {hl_out, acc_out, mem_out, flags_out, memptr_out};
			if (pending_results.size() == 0) begin
				note_mismatch("result word with nothing expected", '0, seen_word);
			end else begin
				oldest_word = pending_results.pop_front();
				if (seen_word.hl !== oldest_word.hl || seen_word.acc !== oldest_word.acc ||
						seen_word.mem !== oldest_word.mem ||
						seen_word.flags !== oldest_word.flags ||
						seen_word.memptr !== oldest_word.memptr)
					note_mismatch("result word mismatch", oldest_word, seen_word);
			end
		end
	end

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// port byte flags: zero with even parity, all ones, sign bit with carry kept,
	// memptr wrap from bc = ffff
	task automatic test_in_flags();
		op_t w;
		w = word_for(CMD_IN);
		w.data = 8'h00;
		w.flags = 8'h00;
		send_word(w);
		w = word_for(CMD_IN);
		w.data = 8'hFF;
		w.flags = 8'hFF;
		w.bc = 16'hFFFF;
		send_word(w);
		w = word_for(CMD_IN);
		w.data = 8'h80;
		w.flags = 8'h01;
		w.bc = 16'h0000;
		send_word(w);
	endtask

	// 16-bit add with carry: wrap to zero, signed overflow, half carry, all zero
	task automatic test_adc_hl();
		op_t w;
		w = word_for(CMD_ADC);
		w.hl = 16'hFFFF;
		w.pair = 16'h0001;
		w.flags = 8'h00;
		send_word(w);
		w = word_for(CMD_ADC);
		w.hl = 16'h7FFF;
		w.pair = 16'h0000;
		w.flags = 8'hFF;
		send_word(w);
		w = word_for(CMD_ADC);
		w.hl = 16'h0FFF;
		w.pair = 16'h0000;
		w.flags = 8'h01;
		send_word(w);
		w = word_for(CMD_ADC);
		w.hl = 16'h0000;
		w.pair = 16'h0000;
		w.flags = 8'hFE;
		send_word(w);
		w = word_for(CMD_ADC);
		w.hl = 16'hFFFF;
		w.pair = 16'hFFFF;
		w.flags = 8'h01;
		send_word(w);
	endtask

	// 16-bit subtract with borrow: borrow through zero, overflow, half borrow,
	// equal operands, subtrahend plus carry reaching 10000 hex
	task automatic test_sbc_hl();
		op_t w;
		w = word_for(CMD_SBC);
		w.hl = 16'h0000;
		w.pair = 16'h0000;
		w.flags = 8'h01;
		send_word(w);
		w = word_for(CMD_SBC);
		w.hl = 16'h8000;
		w.pair = 16'h0001;
		w.flags = 8'h00;
		send_word(w);
		w = word_for(CMD_SBC);
		w.hl = 16'h1000;
		w.pair = 16'h0001;
		w.flags = 8'hFE;
		send_word(w);
		w = word_for(CMD_SBC);
		w.pair = w.hl;
		w.flags = 8'h00;
		send_word(w);
		w = word_for(CMD_SBC);
		w.hl = 16'hFFFF;
		w.pair = 16'hFFFF;
		w.flags = 8'hFF;
		send_word(w);
	endtask

	// load from i/r: zero with iff2 clear, all ones with iff2 set, sign only
	task automatic test_ld_a_ir();
		op_t w;
		w = word_for(CMD_LDI);
		w.ir = 8'h00;
		w.iff2 = 1'b0;
		w.flags = 8'hFF;
		send_word(w);
		w = word_for(CMD_LDI);
		w.ir = 8'hFF;
		w.iff2 = 1'b1;
		w.flags = 8'h00;
		send_word(w);
		w = word_for(CMD_LDI);
		w.ir = 8'h80;
		w.iff2 = 1'b1;
		w.flags = 8'h01;
		send_word(w);
	endtask

	// nibble rotates with extreme accumulator and memory bytes
	task automatic test_nibble_rotate();
		op_t w;
		w = word_for(CMD_RLD);
		w.acc = 8'hFF;
		w.data = 8'h00;
		send_word(w);
		w = word_for(CMD_RLD);
		w.acc = 8'h00;
		w.data = 8'h0F;
		w.hl = 16'hFFFF;
		send_word(w);
		w = word_for(CMD_RRD);
		w.acc = 8'h0F;
		w.data = 8'hF0;
		send_word(w);
		w = word_for(CMD_RRD);
		w.acc = 8'hF0;
		w.data = 8'hFF;
		w.hl = 16'hFFFF;
		send_word(w);
	endtask

	// codes past the last operation pass everything through
	task automatic test_undefined_cmds();
		send_word(word_for(CMD_UNDEF_LO));
		send_word(word_for(CMD_UNDEF_HI));
	endtask

	// ------------------------------------------------------------------
	// random traffic, with a gap-free stretch in the given window
	// ------------------------------------------------------------------

	task automatic test_random_traffic(input int count, input int quiet_lo, input int quiet_hi);
		for (int i = 0; i < count; i++) begin
			gaps_on = (i < quiet_lo || i >= quiet_hi);
			send_word(random_word());
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_in_flags();
		test_adc_hl();
		test_sbc_hl();
		test_ld_a_ir();
		test_nibble_rotate();
		test_undefined_cmds();

		test_random_traffic(700, 200, 450);
		// hold the sender off until the pipe is empty, then resume
		pause_until_drained();
		test_random_traffic(800, 100, 400);

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			mismatch_count += pending_results.size();
		if (mismatch_count == 0)
			$display("ed_page_alu_flag_unit test passed");
		else
			$display("ed_page_alu_flag_unit test failed");
		$finish;
	end

	// hard stop if the block stops answering
	initial begin
		#(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
		$display("ed_page_alu_flag_unit test failed");
		$finish;
	end

endmodule
